// File: rtl/core/dlle_pkg.sv
// ----------------------------------------------------------------------------
// Doubly linked list engine package
// Request codes and result status codes shared by the core and its checker.
// ----------------------------------------------------------------------------
package dlle_pkg;

   typedef enum logic [3:0] {
      ACT_PUSH_FRONT  = 4'd0,
      ACT_PUSH_BACK   = 4'd1,
      ACT_POP_FRONT   = 4'd2,
      ACT_POP_BACK    = 4'd3,
      ACT_FIND_FIRST  = 4'd4,
      ACT_FIND_LAST   = 4'd5,
      ACT_COUNT       = 4'd6,
      ACT_INSERT_AFTER = 4'd7,
      ACT_REMOVE      = 4'd8,
      ACT_CLEAR       = 4'd9
   } action_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_INVALID   = 3'd4
   } status_type;

endpackage

// File: rtl/core/doubly_linked_list_engine_core.sv
// ----------------------------------------------------------------------------
// Doubly linked list engine core
// A bounded doubly linked list kept in a pool of NODES entries with a free
// chain, driven by a small sequencer over single-port link and value memories.
//
//   Channel   Ports                                Handshake
//   request   req_action, req_value, req_node      start high while busy low
//   response  rsp_status ... rsp_is_empty          rsp_valid for one cycle
//
// Push and insert take a free entry and link it in; pop and remove unlink a
// node and return it to the free chain. A full pool, an empty list or a bad
// handle ends early. Find reads and compares one node at a time until a match
// or the end of the list, count walks the whole list, clear rewrites the pool.
// Reset is synchronous; busy stays high for the clearing pass that follows it.
// The response beat cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine_core #(
   parameter int NODES      = 256,
   parameter int VALUE_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [3:0]          req_action,
   input  logic signed [31:0]  req_value,
   input  logic [7:0]          req_node,
   output logic                rsp_valid,
   output logic [2:0]          rsp_status,
   output logic [7:0]          rsp_handle,
   output logic [8:0]          rsp_match_count,
   output logic [8:0]          rsp_length,
   output logic signed [31:0]  rsp_front_value,
   output logic signed [31:0]  rsp_back_value,
   output logic                rsp_is_empty
);

   localparam int IDX_W  = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int LINK_W = $clog2(NODES + 1);
   localparam logic [LINK_W-1:0] NIL = LINK_W'(NODES);

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_CLR   = 13'b0000000000010,
      S_DISP  = 13'b0000000000100,
      S_CHK   = 13'b0000000001000,
      S_TAKE  = 13'b0000000010000,
      S_LINK  = 13'b0000000100000,
      S_UNL   = 13'b0000001000000,
      S_UNL2  = 13'b0000010000000,
      S_WALK  = 13'b0000100000000,
      S_CMP   = 13'b0001000000000,
      S_FIN   = 13'b0010000000000,
      S_FRONT = 13'b0100000000000,
      S_BACK  = 13'b1000000000000
   } state_type;

   logic [VALUE_BITS-1:0] val_mem [NODES];
   logic [LINK_W-1:0]     nxt_mem [NODES];
   logic [LINK_W-1:0]     prv_mem [NODES];
   logic                  use_mem [NODES];

   state_type             state_ff, state_in;
   logic [3:0]            act_ff, act_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [7:0]            node_ff, node_in;
   logic [LINK_W-1:0]     head_ff, head_in, tail_ff, tail_in, free_ff, free_in;
   logic [LINK_W-1:0]     count_ff, count_in, match_ff, match_in;
   logic [LINK_W-1:0]     cur_ff, cur_in, tmp_ff, tmp_in;
   logic [2:0]            status_ff, status_in;
   logic [LINK_W-1:0]     handle_ff, handle_in;
   logic [VALUE_BITS-1:0] front_ff, front_in;
   logic                  init_ff, init_in;

   logic                  rsp_valid_ff;
   logic [2:0]            rsp_status_ff;
   logic [7:0]            rsp_handle_ff;
   logic [8:0]            rsp_match_ff, rsp_length_ff;
   logic [31:0]           rsp_front_ff, rsp_back_ff;
   logic                  rsp_empty_ff;
   logic                  rsp_load;

   logic                  val_re, nxt_re, prv_re, use_re;
   logic [IDX_W-1:0]      val_ra, nxt_ra, prv_ra, use_ra;
   logic [VALUE_BITS-1:0] val_q;
   logic [LINK_W-1:0]     nxt_q, prv_q;
   logic                  use_q;

   logic                  val_we, nxt_we, prv_we, use_we;
   logic [IDX_W-1:0]      val_wa, nxt_wa, prv_wa, use_wa;
   logic [VALUE_BITS-1:0] val_wd;
   logic [LINK_W-1:0]     nxt_wd, prv_wd;
   logic                  use_wd;

   logic [LINK_W-1:0]     sel_end;
   logic                  node_in_range;

   assign busy          = (state_ff != S_IDLE);
   assign node_in_range = (32'(node_ff) < NODES);

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_wa] <= val_wd;
      end
      if (nxt_we) begin
         nxt_mem[nxt_wa] <= nxt_wd;
      end
      if (prv_we) begin
         prv_mem[prv_wa] <= prv_wd;
      end
      if (use_we) begin
         use_mem[use_wa] <= use_wd;
      end
      if (val_re) begin
         val_q <= val_mem[val_ra];
      end
      if (nxt_re) begin
         nxt_q <= nxt_mem[nxt_ra];
      end
      if (prv_re) begin
         prv_q <= prv_mem[prv_ra];
      end
      if (use_re) begin
         use_q <= use_mem[use_ra];
      end
   end

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      val_in    = val_ff;
      node_in   = node_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      free_in   = free_ff;
      count_in  = count_ff;
      match_in  = match_ff;
      cur_in    = cur_ff;
      tmp_in    = tmp_ff;
      status_in = status_ff;
      handle_in = handle_ff;
      front_in  = front_ff;
      init_in   = init_ff;
      rsp_load  = 1'b0;
      val_re = 1'b0; nxt_re = 1'b0; prv_re = 1'b0; use_re = 1'b0;
      val_ra = cur_ff[IDX_W-1:0];
      nxt_ra = cur_ff[IDX_W-1:0];
      prv_ra = cur_ff[IDX_W-1:0];
      use_ra = cur_ff[IDX_W-1:0];
      val_we = 1'b0; nxt_we = 1'b0; prv_we = 1'b0; use_we = 1'b0;
      val_wa = cur_ff[IDX_W-1:0];
      nxt_wa = cur_ff[IDX_W-1:0];
      prv_wa = cur_ff[IDX_W-1:0];
      use_wa = cur_ff[IDX_W-1:0];
      val_wd = val_ff;
      nxt_wd = NIL;
      prv_wd = NIL;
      use_wd = 1'b0;
      sel_end = (act_ff == dlle_pkg::ACT_POP_FRONT || act_ff == dlle_pkg::ACT_FIND_FIRST ||
                 act_ff == dlle_pkg::ACT_COUNT) ? head_ff : tail_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in    = req_action;
               val_in    = VALUE_BITS'($unsigned(req_value));
               node_in   = req_node;
               status_in = dlle_pkg::ST_OK;
               handle_in = '0;
               match_in  = '0;
               state_in  = S_DISP;
            end
         end
         S_CLR: begin
            nxt_we = 1'b1;
            nxt_wd = cur_ff + 1'b1;
            use_we = 1'b1;
            use_wd = 1'b0;
            cur_in = cur_ff + 1'b1;
            if (cur_ff[IDX_W-1:0] == IDX_W'(NODES - 1)) begin
               head_in  = NIL;
               tail_in  = NIL;
               free_in  = '0;
               count_in = '0;
               init_in  = 1'b0;
               state_in = init_ff ? S_IDLE : S_FIN;
            end
         end
         S_DISP: begin
            state_in = S_FIN;
            unique case (act_ff)
               dlle_pkg::ACT_PUSH_FRONT, dlle_pkg::ACT_PUSH_BACK: begin
                  if (free_ff == NIL) begin
                     status_in = dlle_pkg::ST_FULL;
                  end else begin
                     nxt_re   = 1'b1;
                     nxt_ra   = free_ff[IDX_W-1:0];
                     state_in = S_TAKE;
                  end
               end
               dlle_pkg::ACT_POP_FRONT, dlle_pkg::ACT_POP_BACK: begin
                  if (sel_end == NIL) begin
                     status_in = dlle_pkg::ST_EMPTY;
                  end else begin
                     cur_in   = sel_end;
                     nxt_re   = 1'b1;
                     prv_re   = 1'b1;
                     nxt_ra   = sel_end[IDX_W-1:0];
                     prv_ra   = sel_end[IDX_W-1:0];
                     state_in = S_UNL;
                  end
               end
               dlle_pkg::ACT_FIND_FIRST, dlle_pkg::ACT_FIND_LAST: begin
                  status_in = dlle_pkg::ST_NOT_FOUND;
                  cur_in    = sel_end;
                  state_in  = S_WALK;
               end
               dlle_pkg::ACT_COUNT: begin
                  cur_in   = sel_end;
                  state_in = S_WALK;
               end
               dlle_pkg::ACT_INSERT_AFTER, dlle_pkg::ACT_REMOVE: begin
                  if (!node_in_range) begin
                     status_in = dlle_pkg::ST_INVALID;
                  end else begin
                     cur_in   = LINK_W'(node_ff);
                     use_re   = 1'b1;
                     nxt_re   = 1'b1;
                     prv_re   = 1'b1;
                     use_ra   = IDX_W'(node_ff);
                     nxt_ra   = IDX_W'(node_ff);
                     prv_ra   = IDX_W'(node_ff);
                     state_in = S_CHK;
                  end
               end
               dlle_pkg::ACT_CLEAR: begin
                  cur_in   = '0;
                  state_in = S_CLR;
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end
         S_CHK: begin
            tmp_in = nxt_q;
            if (!use_q) begin
               status_in = dlle_pkg::ST_INVALID;
               state_in  = S_FIN;
            end else if (act_ff == dlle_pkg::ACT_REMOVE) begin
               state_in = S_UNL;
            end else if (free_ff == NIL) begin
               status_in = dlle_pkg::ST_FULL;
               state_in  = S_FIN;
            end else begin
               nxt_re   = 1'b1;
               nxt_ra   = free_ff[IDX_W-1:0];
               state_in = S_TAKE;
            end
         end
         S_TAKE: begin
            free_in   = nxt_q;
            count_in  = count_ff + 1'b1;
            cur_in    = free_ff;
            handle_in = free_ff;
            use_we    = 1'b1;
            use_wa    = free_ff[IDX_W-1:0];
            use_wd    = 1'b1;
            val_we    = 1'b1;
            val_wa    = free_ff[IDX_W-1:0];
            nxt_we    = 1'b1;
            nxt_wa    = free_ff[IDX_W-1:0];
            prv_we    = 1'b1;
            prv_wa    = free_ff[IDX_W-1:0];
            if (act_ff == dlle_pkg::ACT_PUSH_FRONT) begin
               nxt_wd = head_ff;
               prv_wd = NIL;
            end else if (act_ff == dlle_pkg::ACT_PUSH_BACK) begin
               nxt_wd = NIL;
               prv_wd = tail_ff;
            end else begin
               nxt_wd = tmp_ff;
               prv_wd = LINK_W'(node_ff);
            end
            state_in = S_LINK;
         end
         S_LINK: begin
            state_in = S_FIN;
            if (act_ff == dlle_pkg::ACT_PUSH_FRONT) begin
               if (head_ff == NIL) begin
                  tail_in = cur_ff;
               end else begin
                  prv_we = 1'b1;
                  prv_wa = head_ff[IDX_W-1:0];
                  prv_wd = cur_ff;
               end
               head_in = cur_ff;
            end else if (act_ff == dlle_pkg::ACT_PUSH_BACK) begin
               if (tail_ff == NIL) begin
                  head_in = cur_ff;
               end else begin
                  nxt_we = 1'b1;
                  nxt_wa = tail_ff[IDX_W-1:0];
                  nxt_wd = cur_ff;
               end
               tail_in = cur_ff;
            end else begin
               nxt_we = 1'b1;
               nxt_wa = IDX_W'(node_ff);
               nxt_wd = cur_ff;
               if (tmp_ff == NIL) begin
                  tail_in = cur_ff;
               end else begin
                  prv_we = 1'b1;
                  prv_wa = tmp_ff[IDX_W-1:0];
                  prv_wd = cur_ff;
               end
            end
         end
         S_UNL: begin
            if (prv_q == NIL) begin
               head_in = nxt_q;
            end else begin
               nxt_we = 1'b1;
               nxt_wa = prv_q[IDX_W-1:0];
               nxt_wd = nxt_q;
            end
            if (nxt_q == NIL) begin
               tail_in = prv_q;
            end else begin
               prv_we = 1'b1;
               prv_wa = nxt_q[IDX_W-1:0];
               prv_wd = prv_q;
            end
            use_we   = 1'b1;
            use_wd   = 1'b0;
            state_in = S_UNL2;
         end
         S_UNL2: begin
            nxt_we   = 1'b1;
            nxt_wd   = free_ff;
            free_in  = cur_ff;
            count_in = count_ff - 1'b1;
            state_in = S_FIN;
         end
         S_WALK: begin
            if (cur_ff == NIL) begin
               state_in = S_FIN;
            end else begin
               val_re   = 1'b1;
               nxt_re   = 1'b1;
               prv_re   = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_WALK;
            if (act_ff == dlle_pkg::ACT_COUNT) begin
               if (val_q == val_ff) begin
                  match_in = match_ff + 1'b1;
               end
               cur_in = nxt_q;
            end else if (val_q == val_ff) begin
               status_in = dlle_pkg::ST_OK;
               handle_in = cur_ff;
               state_in  = S_FIN;
            end else begin
               cur_in = (act_ff == dlle_pkg::ACT_FIND_FIRST) ? nxt_q : prv_q;
            end
         end
         S_FIN: begin
            val_re   = 1'b1;
            val_ra   = head_ff[IDX_W-1:0];
            state_in = S_FRONT;
         end
         S_FRONT: begin
            front_in = (head_ff == NIL) ? '0 : val_q;
            val_re   = 1'b1;
            val_ra   = tail_ff[IDX_W-1:0];
            state_in = S_BACK;
         end
         S_BACK: begin
            rsp_load = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         cur_ff       <= '0;
         init_ff      <= 1'b1;
         head_ff      <= NIL;
         tail_ff      <= NIL;
         free_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         init_ff      <= init_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      val_ff    <= val_in;
      node_ff   <= node_in;
      match_ff  <= match_in;
      tmp_ff    <= tmp_in;
      status_ff <= status_in;
      handle_ff <= handle_in;
      front_ff  <= front_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_handle_ff <= (status_ff == dlle_pkg::ST_OK) ? 8'(handle_ff) : 8'd0;
         rsp_match_ff  <= 9'(match_ff);
         rsp_length_ff <= 9'(count_ff);
         rsp_front_ff  <= 32'(front_ff);
         rsp_back_ff   <= (tail_ff == NIL) ? 32'd0 : 32'(val_q);
         rsp_empty_ff  <= (count_ff == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_handle      = rsp_handle_ff;
   assign rsp_match_count = rsp_match_ff;
   assign rsp_length      = rsp_length_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_back_value  = rsp_back_ff;
   assign rsp_is_empty    = rsp_empty_ff;

endmodule

// File: rtl/core/dlle_checker.sv
// ----------------------------------------------------------------------------
// Doubly linked list engine checker
// Port-level checks on the request and response beats of the core.
// ----------------------------------------------------------------------------
module dlle_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [2:0]  rsp_status,
   input logic [7:0]  rsp_handle,
   input logic [8:0]  rsp_length,
   input logic [31:0] rsp_front_value,
   input logic [31:0] rsp_back_value,
   input logic        rsp_is_empty
);

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy did not rise after a request beat");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response beat while busy");

   a_empty_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_length == 9'd0)))
      else $error("empty flag disagrees with length");

   a_empty_values: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_front_value == 32'd0 && rsp_back_value == 32'd0)
      else $error("empty list reported nonzero end values");

   a_handle_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != dlle_pkg::ST_OK |-> rsp_handle == 8'd0)
      else $error("nonzero handle with a failing status");

endmodule

bind doubly_linked_list_engine_core dlle_checker u_dlle_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_handle      (rsp_handle),
   .rsp_length      (rsp_length),
   .rsp_front_value (rsp_front_value),
   .rsp_back_value  (rsp_back_value),
   .rsp_is_empty    (rsp_is_empty)
);
